### src/ppci_pkg.sv
// Shared types, constants and the CRC-32 byte update for the pHYs chunk inserter.
package ppci_pkg;

  localparam int unsigned PosW       = 6;
  localparam int unsigned IdxW       = 5;
  localparam int unsigned PpmW       = 32;

  localparam logic [PosW-1:0] InsertAt   = 6'd33;
  localparam logic [IdxW-1:0] ChunkLast  = 5'd20;

  // Byte positions inside the 21-byte pHYs chunk.
  localparam logic [IdxW-1:0] IdxLen3    = 5'd3;
  localparam logic [IdxW-1:0] IdxTagP    = 5'd4;
  localparam logic [IdxW-1:0] IdxTagH    = 5'd5;
  localparam logic [IdxW-1:0] IdxTagY    = 5'd6;
  localparam logic [IdxW-1:0] IdxTagS    = 5'd7;
  localparam logic [IdxW-1:0] IdxPx0     = 5'd8;
  localparam logic [IdxW-1:0] IdxPx1     = 5'd9;
  localparam logic [IdxW-1:0] IdxPx2     = 5'd10;
  localparam logic [IdxW-1:0] IdxPx3     = 5'd11;
  localparam logic [IdxW-1:0] IdxPy0     = 5'd12;
  localparam logic [IdxW-1:0] IdxPy1     = 5'd13;
  localparam logic [IdxW-1:0] IdxPy2     = 5'd14;
  localparam logic [IdxW-1:0] IdxPy3     = 5'd15;
  localparam logic [IdxW-1:0] IdxUnit    = 5'd16;
  localparam logic [IdxW-1:0] IdxCrc0    = 5'd17;
  localparam logic [IdxW-1:0] IdxCrc1    = 5'd18;
  localparam logic [IdxW-1:0] IdxCrc2    = 5'd19;
  localparam logic [IdxW-1:0] IdxCrc3    = 5'd20;

  localparam logic [7:0]  DataLen   = 8'd9;
  localparam logic [7:0]  UnitMetre = 8'd1;
  localparam logic [31:0] CrcPoly   = 32'hEDB88320;
  localparam logic [31:0] CrcOnes   = 32'hFFFFFFFF;

  typedef struct packed {
    logic            start;
    logic            advance;
    logic            last;
    logic [PpmW-1:0] ppm;
  } gen_ctl_t;

  typedef struct packed {
    logic       active;
    logic [7:0] data;
    logic       last;
  } gen_st_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### src/png_phys_chunk_inserter_unit.sv
// Top level of the PNG pHYs chunk inserter: byte counter, config register, output register.
// An accepted byte is registered and appears on the output in the following cycle.
// Throughput: one byte per cycle while the output is not stalled; after the 33rd byte of a
// stream with a nonzero resolution the 21 chunk bytes follow at that rate, input held off.
// The chunk CRC is built one byte per cycle as the chunk streams out, unless it stalls.
// Reset clears the byte counter, the resolution register and the output valid.
module png_phys_chunk_inserter_unit import ppci_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [PpmW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);

  logic [PpmW-1:0] ppm_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_byte_q;
  logic            out_last_q;
  logic            load_en;
  logic            in_fire;
  logic            insert;
  gen_ctl_t        gen_ctl;
  gen_st_t         gen_st;

  // The output register can take a new byte when it is empty or being drained.
  assign load_en    = !out_valid_q || out_ready_i;
  // While the chunk is streaming, the chunk owns the output register.
  assign in_ready_o = load_en && !gen_st.active;
  assign in_fire    = in_valid_i && in_ready_o;

  // The 33rd byte of a stream triggers the chunk when a resolution is set.
  assign insert = in_fire && (pos_q == InsertAt - 1'b1) && (ppm_q != '0);

  always_comb begin
    pos_d = pos_q;
    if (in_fire) begin
      if (in_last_i) begin
        pos_d = '0;
      end else if (pos_q < InsertAt) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  assign gen_ctl.start   = insert;
  assign gen_ctl.advance = load_en && gen_st.active;
  assign gen_ctl.last    = in_last_i;
  assign gen_ctl.ppm     = ppm_q;

  ppci_chunk_gen u_chunk_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (gen_ctl),
    .st_o   (gen_st)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_en) begin
      out_valid_d = gen_st.active || in_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppm_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ppm_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload: chunk bytes take priority; the triggering byte never carries last.
  always_ff @(posedge clk_i) begin
    if (load_en) begin
      if (gen_st.active) begin
        out_byte_q <= gen_st.data;
        out_last_q <= gen_st.last;
      end else if (in_fire) begin
        out_byte_q <= in_byte_i;
        out_last_q <= in_last_i && !insert;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

`ifndef NO_ASSERTIONS
  a_no_input_during_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_st.active |-> !in_ready_o)
    else $error("input accepted while the chunk is streaming");

  a_start_activates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_ctl.start |=> gen_st.active)
    else $error("chunk did not start after the trigger byte");

  a_pos_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= InsertAt)
    else $error("byte counter passed its saturation point");

  a_chunk_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gen_st.active && load_en) |=> out_valid_o)
    else $error("chunk byte not loaded into the output register");
`endif

endmodule

### src/ppci_chunk_gen.sv
// Byte sequencer for the pHYs chunk with a running CRC-32 over tag and data.
module ppci_chunk_gen import ppci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  gen_ctl_t ctl_i,
  output gen_st_t  st_o
);

  logic            active_q, active_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [31:0]     crc_q, crc_d;
  logic [PpmW-1:0] ppm_q;
  logic            last_q;
  logic [31:0]     crc_fin;
  logic [7:0]      data;

  assign crc_fin = crc_q ^ CrcOnes;

  always_comb begin
    case (idx_q)
      IdxLen3: data = DataLen;
      IdxTagP: data = 8'h70;
      IdxTagH: data = 8'h48;
      IdxTagY: data = 8'h59;
      IdxTagS: data = 8'h73;
      IdxPx0, IdxPy0: data = ppm_q[31:24];
      IdxPx1, IdxPy1: data = ppm_q[23:16];
      IdxPx2, IdxPy2: data = ppm_q[15:8];
      IdxPx3, IdxPy3: data = ppm_q[7:0];
      IdxUnit: data = UnitMetre;
      IdxCrc0: data = crc_fin[31:24];
      IdxCrc1: data = crc_fin[23:16];
      IdxCrc2: data = crc_fin[15:8];
      IdxCrc3: data = crc_fin[7:0];
      default: data = 8'd0;
    endcase
  end

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    crc_d    = crc_q;
    if (ctl_i.start) begin
      active_d = 1'b1;
      idx_d    = '0;
      crc_d    = CrcOnes;
    end else if (ctl_i.advance && active_q) begin
      idx_d = idx_q + 1'b1;
      if (idx_q >= IdxTagP && idx_q <= IdxUnit) begin
        crc_d = crc_byte(crc_q, data);
      end
      if (idx_q == ChunkLast) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    if (ctl_i.start) begin
      ppm_q  <= ctl_i.ppm;
      last_q <= ctl_i.last;
    end
  end

  assign st_o.active = active_q;
  assign st_o.data   = data;
  assign st_o.last   = last_q && (idx_q == ChunkLast);

endmodule

### verif/tb_png_phys_chunk_inserter_unit.sv
// Testbench for the PNG pHYs chunk inserter: directed and random streams, predictor-checked.
module tb_png_phys_chunk_inserter_unit;
  import ppci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limit in clock cycles. The slowest correct run (every stream inserting,
  // every output byte waiting out the longest receiver stall) stays far below this.
  localparam int unsigned CycleLimit = 600000;
  // Result count at which the receiver holds off once for a long stretch.
  localparam int unsigned SqueezeAt  = 60;
  localparam int unsigned SqueezeLen = 150;
  localparam int unsigned ChunkBytes = 21;
  // The four tag bytes of the chunk, in stream order.
  localparam logic [31:0] PhysTag    = "pHYs";

  // One byte of a stream, as it travels on either side of the block.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i;
  logic [PpmW-1:0] cfg_wdata_i;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [7:0]      in_byte_i = 8'h00;
  logic            in_last_i = 1'b0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic [7:0]      out_byte_o;
  logic            out_last_o;

  png_phys_chunk_inserter_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // 2 ns clock period.
  always #1 clk_i = ~clk_i;

  // Bytes waiting to be offered to the block, filled by the stimulus process.
  stream_byte_t    bytes_to_send[$];
  // Output bytes the block owes us, oldest first.
  stream_byte_t    bytes_owed[$];

  // Predictor state: the resolution register and the position within the stream.
  logic [PpmW-1:0] pred_ppm;
  logic [PosW-1:0] pred_pos;

  // When set, neither side inserts random idle cycles, giving back-to-back traffic.
  logic            steady_phase = 1'b0;

  int unsigned     fail_count = 0;
  int unsigned     results_seen = 0;
  int unsigned     cycle_count = 0;
  int unsigned     send_gap = 0;
  int unsigned     hold_left = 0;
  stream_byte_t    got_want;

  // Gap length in cycles: mostly none or short, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // Reflected CRC-32, fed one data bit at a time, least significant bit first.
  function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] data);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CrcPoly;
    end
    return crc;
  endfunction

  // Works out the output bytes caused by one accepted input byte and queues them.
  // The 33rd byte of a stream is passed and, with a nonzero resolution, followed
  // by the whole pHYs chunk. A last flag on that byte moves to the chunk's final
  // CRC byte. Any last flag starts a new stream.
  function automatic void predict_output(input logic [7:0] data, input logic last);
    logic           insert;
    logic [135:0]   body;
    logic [167:0]   chunk;
    logic [31:0]    crc;
    stream_byte_t   item;
    insert = 1'b0;
    if (pred_pos < InsertAt) begin
      pred_pos = pred_pos + 1'b1;
      insert   = (pred_pos == InsertAt) && (pred_ppm != '0);
    end
    item.data = data;
    item.last = last && !insert;
    bytes_owed.push_back(item);
    if (insert) begin
      // Length, tag, x and y resolution, unit; the CRC covers all but the length.
      body = {24'h000000, DataLen, PhysTag, pred_ppm, pred_ppm, UnitMetre};
      crc  = CrcOnes;
      for (int i = 4; i < 17; i++) crc = crc32_feed(crc, body[135 - 8*i -: 8]);
      chunk = {body, crc ^ CrcOnes};
      for (int i = 0; i < ChunkBytes; i++) begin
        item.data = chunk[167 - 8*i -: 8];
        item.last = last && (i == ChunkLast);
        bytes_owed.push_back(item);
      end
    end
    if (last) pred_pos = '0;
  endfunction

  function automatic void report_mismatch(input string what, input int unsigned want,
                                          input int unsigned got);
    fail_count++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
  endfunction

  // Sender. Predicts at each accepted item, then offers the next queued byte
  // after a random gap. A byte on offer stays put until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= 8'h00;
      in_last_i  <= 1'b0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_output(in_byte_i, in_last_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (bytes_to_send.size() > 0) begin
          in_valid_i <= 1'b1;
          in_byte_i  <= bytes_to_send[0].data;
          in_last_i  <= bytes_to_send[0].last;
          bytes_to_send.delete(0);
          send_gap = steady_phase ? 0 : idle_cycles();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver. Checks each accepted item against the oldest owed byte and stalls
  // at random. Once, partway in, it stops taking bytes for a long stretch while
  // the sender keeps offering, so the block fills up and holds off its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (bytes_owed.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected item, expected none, actual byte 0x%0h last %0b",
                   $time, out_byte_o, out_last_o);
        end else begin
          got_want = bytes_owed.pop_front();
          if (got_want.data !== out_byte_o) report_mismatch("out_byte", got_want.data, out_byte_o);
          if (got_want.last !== out_last_o) report_mismatch("out_last", got_want.last, out_last_o);
        end
        if (results_seen == SqueezeAt) hold_left = SqueezeLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady_phase) hold_left = idle_cycles();
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Waits until every queued byte is taken and every owed byte has arrived.
  // Sampling at the falling edge keeps this clear of the clocked processes.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (bytes_to_send.size() != 0 || in_valid_i || bytes_owed.size() != 0);
    // Every byte yields output, so once drained the block is idle; the extra
    // wait below covers the output register.
    repeat (2) @(negedge clk_i);
  endtask

  // Writes the resolution register; only called while the block is idle.
  task automatic set_resolution(input logic [PpmW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pred_ppm = value;
  endtask

  task automatic queue_byte(input logic [7:0] data, input logic last);
    stream_byte_t item;
    item.data = data;
    item.last = last;
    bytes_to_send.push_back(item);
  endtask

  // Resolution settings for the random phases, extremes included.
  logic [PpmW-1:0] phase_ppm[8];
  int unsigned     stream_left;
  int unsigned     phase_len;
  int unsigned     roll;

  initial begin
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    pred_ppm    = '0;
    pred_pos    = '0;
    stream_left = 0;
    phase_ppm   = '{32'h0000_0000, 32'h0000_0001, $urandom(), 32'h8000_0000,
                    $urandom(), 32'hFFFF_FFFF, 32'h0000_0000, $urandom()};

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with all-ones resolution: a one-byte stream, then a stream
    // that ends right on its 33rd byte, so the last flag must move to the end
    // of the inserted chunk. Bytes alternate between all zeros and all ones.
    set_resolution(32'hFFFF_FFFF);
    queue_byte(8'hFF, 1'b1);
    for (int i = 1; i <= InsertAt; i++) queue_byte((i % 2) ? 8'h00 : 8'hFF, i == InsertAt);
    wait_drained();

    // Random phases. A stream may straddle a phase boundary, so a register write
    // can land mid-stream and must only take effect if the 33rd byte is still ahead.
    foreach (phase_ppm[p]) begin
      set_resolution(phase_ppm[p]);
      steady_phase = ($urandom_range(3) == 0);
      phase_len    = $urandom_range(20, 10);
      for (int n = 0; n < phase_len; n++) begin
        if (stream_left == 0) begin
          // Pick the next stream length: short ones, one short of the chunk
          // point, exactly on it, just past it, and long saturating ones.
          roll = $urandom_range(9);
          if (roll < 2)       stream_left = $urandom_range(8, 1);
          else if (roll == 2) stream_left = InsertAt - 1;
          else if (roll < 5)  stream_left = InsertAt;
          else if (roll == 5) stream_left = InsertAt + 1;
          else                stream_left = $urandom_range(60, 35);
        end
        stream_left--;
        queue_byte(8'($urandom_range(255)), stream_left == 0);
      end
      wait_drained();
    end

    steady_phase = 1'b0;
    wait_drained();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/ppci_pkg.sv
src/ppci_chunk_gen.sv
src/png_phys_chunk_inserter_unit.sv
verif/tb_png_phys_chunk_inserter_unit.sv
